FILE: rtl/core/meeu_pkg.sv
package meeu_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_UPD,
    ST_RED,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic mul_step;
    logic upd;
    logic red;
  } cmd_t;

  typedef struct packed {
    logic zero_op;
    logic r1_zero;
    logic div_last;
    logic mul_last;
  } sts_t;

endpackage

FILE: rtl/core/meeu_ctrl.sv
module meeu_ctrl import meeu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy,
  output logic done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.zero_op || sts_i.r1_zero) begin
          state_d = ST_RED;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          cmd_o.upd = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_RED: begin
        cmd_o.red = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/meeu_dpath.sv
module meeu_dpath import meeu_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic             clk_i,
  input  logic [63:0]      modulus_i,
  input  logic [63:0]      operand_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic [WIDTH-1:0] gcd_o,
  output logic [WIDTH-1:0] inv_o,
  output logic             has_inv_o,
  output logic             zero_o
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] m_q, r0_q, r1_q, t0_q, t1_q;
  logic             t0n_q, t1n_q;
  // divider: restoring, one quotient bit per cycle
  logic [WIDTH-1:0] q_q, rem_q, dvd_q;
  logic [CW-1:0]    cnt_q;
  // multiplier: shift-add q*t1 plus t0, one bit per cycle
  logic [WIDTH-1:0] acc_q, mq_q, mt_q;
  logic [WIDTH-1:0] inv_q;
  logic             zero_q;

  logic [WIDTH:0]   trial;
  logic [WIDTH-1:0] rsh;
  logic [WIDTH-1:0] mag;

  assign rsh   = {rem_q[WIDTH-2:0], dvd_q[WIDTH-1]};
  assign trial = {rem_q[WIDTH-1], rsh} - {1'b0, r1_q};

  assign mag = (t0_q >= m_q) ? t0_q - m_q : t0_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q    <= modulus_i[WIDTH-1:0];
      r0_q   <= modulus_i[WIDTH-1:0];
      r1_q   <= operand_i[WIDTH-1:0];
      t0_q   <= '0;
      t1_q   <= {{(WIDTH-1){1'b0}}, 1'b1};
      t0n_q  <= 1'b1;
      t1n_q  <= 1'b0;
      zero_q <= (operand_i[WIDTH-1:0] == '0);
    end
    if (cmd_i.div_start) begin
      dvd_q <= r0_q;
      rem_q <= '0;
      q_q   <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (!trial[WIDTH]) begin
        rem_q <= trial[WIDTH-1:0];
        q_q   <= {q_q[WIDTH-2:0], 1'b1};
      end else begin
        rem_q <= rsh;
        q_q   <= {q_q[WIDTH-2:0], 1'b0};
      end
      dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(WIDTH-1)) begin
        acc_q <= t0_q;
        mq_q  <= trial[WIDTH] ? {q_q[WIDTH-2:0], 1'b0} : {q_q[WIDTH-2:0], 1'b1};
        mt_q  <= t1_q;
      end
    end
    if (cmd_i.mul_step) begin
      if (mq_q[0]) begin
        acc_q <= acc_q + mt_q;
      end
      mq_q <= mq_q >> 1;
      mt_q <= mt_q << 1;
    end
    if (cmd_i.upd) begin
      r0_q  <= r1_q;
      r1_q  <= rem_q;
      t0_q  <= t1_q;
      t1_q  <= mq_q[0] ? acc_q + mt_q : acc_q;
      t0n_q <= t1n_q;
      t1n_q <= t0n_q;
    end
    if (cmd_i.red) begin
      if (zero_q || r0_q != {{(WIDTH-1){1'b0}}, 1'b1}) begin
        inv_q <= '0;
      end else if (m_q == '0) begin
        inv_q <= t0_q;
      end else if (t0n_q && mag != '0) begin
        inv_q <= m_q - mag;
      end else begin
        inv_q <= mag;
      end
    end
  end

  assign sts_o.zero_op  = zero_q;
  assign sts_o.r1_zero  = (r1_q == '0);
  assign sts_o.div_last = (cnt_q == CW'(WIDTH-1));
  assign sts_o.mul_last = (mq_q[WIDTH-1:1] == '0);

  assign gcd_o     = zero_q ? m_q : r0_q;
  assign inv_o     = inv_q;
  assign has_inv_o = !zero_q && (r0_q == {{(WIDTH-1){1'b0}}, 1'b1});
  assign zero_o    = zero_q;

endmodule

FILE: rtl/core/modular_inverse_ext_euclid_core.sv
// gcd and modular inverse by the extended euclidean algorithm. an item is
// taken when start is high and busy is low; results are held in registers
// and are valid when done_o is high for one cycle, which cannot be stalled.
// each remainder step runs a bit-serial divider and a shift-add multiplier
// that stops once the remaining quotient bits are zero, for up to about
// 1.44*WIDTH steps; a zero operand skips straight to the reduction step.
module modular_inverse_ext_euclid_core import meeu_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] modulus_i,
  input  logic [63:0] operand_i,
  output logic        done_o,
  output logic [63:0] gcd_value_o,
  output logic [63:0] inverse_value_o,
  output logic        has_inverse_o,
  output logic        zero_operand_o
);

  cmd_t             cmd;
  sts_t             sts;
  logic [WIDTH-1:0] gcd, inv;

  meeu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  meeu_dpath #(.WIDTH(WIDTH)) u_dpath (
    .clk_i     (clk_i),
    .modulus_i (modulus_i),
    .operand_i (operand_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .gcd_o     (gcd),
    .inv_o     (inv),
    .has_inv_o (has_inverse_o),
    .zero_o    (zero_operand_o)
  );

  assign gcd_value_o     = 64'(gcd);
  assign inverse_value_o = 64'(inv);

endmodule
